@@ rtl/bntg_pkg.sv @@
// ----------------------------------------------------------------------------
// bntg_pkg
// Shared types and constants of the buzzer note tone generator: operation
// codes, divider operand selects, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bntg_pkg;

  // field widths
  localparam int unsigned FreqW   = 16;
  localparam int unsigned BeatW   = 8;
  localparam int unsigned DivW    = 20;
  localparam int unsigned PeriodW = 19;
  localparam int unsigned RestW   = 10;

  // timing constants
  localparam logic [DivW-1:0] UsPerSecond  = DivW'(1000000);
  localparam logic [DivW-1:0] HalfSecondUs = DivW'(500000);
  localparam logic [DivW-1:0] MsPerSecond  = DivW'(1000);
  localparam logic [DivW-1:0] UsPerMs      = DivW'(1000);

  // operation codes (tuser)
  localparam logic OpTick  = 1'b0;
  localparam logic OpStart = 1'b1;

  // register indexes
  localparam logic RegBeatRate = 1'b0;
  localparam logic [BeatW-1:0] BeatRateReset = BeatW'(2);

  // divider operand select
  typedef enum logic [1:0] {
    DIV_REST,   // 1000 / beat
    DIV_BEAT,   // 500000 / beat
    DIV_HP,     // (1000000 + f/2) / f
    DIV_NUM     // (500000 / beat) / half period
  } div_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT_REST,
    ST_WAIT_BEAT,
    ST_WAIT_HP,
    ST_WAIT_NUM,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic     tick_apply;
    logic     start_accept;
    logic     div_start;
    div_sel_e div_sel;
    logic     beat_keep;
    logic     hp_keep;
    logic     rest_load;
    logic     tone_load;
  } cmd_t;

  typedef struct packed {
    logic op_start;
    logic freq_zero;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/bntg_div.sv @@
// ----------------------------------------------------------------------------
// bntg_div
// Restoring unsigned divider, one quotient bit per cycle. A start pulse
// loads the operands; done pulses for one cycle when the quotient is ready
// and the quotient holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module bntg_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [bntg_pkg::DivW-1:0]   dividend_i,
  input  wire logic [bntg_pkg::DivW-1:0]   divisor_i,
  output      logic [bntg_pkg::DivW-1:0]   quotient_o,
  output      logic                        done_o
);

  localparam int unsigned W  = bntg_pkg::DivW;
  localparam int unsigned CW = $clog2(W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  dq_q, dq_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;

  // trial subtract of the shifted partial remainder
  assign shifted = {rem_q, dq_q[W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = (shifted >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dq_d   = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[W-1:0] : shifted[W-1:0];
      dq_d  = {dq_q[W-2:0], ge};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and remainder registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = dq_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

@@ rtl/bntg_ctrl.sv @@
// ----------------------------------------------------------------------------
// bntg_ctrl
// Controller: takes one beat at a time, sequences the divisions of a note
// start and holds the result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bntg_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  output      logic           out_valid_o,
  input  wire logic           out_ready_i,
  input  wire bntg_pkg::sts_t sts_i,
  output      bntg_pkg::cmd_t cmd_o
);

  bntg_pkg::ctrl_state_e state_q, state_d;
  logic                  accept;

  assign accept = in_valid_i && (state_q == bntg_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bntg_pkg::ST_IDLE: begin
        if (accept) begin
          if (!sts_i.op_start) begin
            state_d = bntg_pkg::ST_OUT;
          end else if (sts_i.freq_zero) begin
            state_d = bntg_pkg::ST_WAIT_REST;
          end else begin
            state_d = bntg_pkg::ST_WAIT_BEAT;
          end
        end
      end
      bntg_pkg::ST_WAIT_REST: if (sts_i.div_done) state_d = bntg_pkg::ST_OUT;
      bntg_pkg::ST_WAIT_BEAT: if (sts_i.div_done) state_d = bntg_pkg::ST_WAIT_HP;
      bntg_pkg::ST_WAIT_HP:   if (sts_i.div_done) state_d = bntg_pkg::ST_WAIT_NUM;
      bntg_pkg::ST_WAIT_NUM:  if (sts_i.div_done) state_d = bntg_pkg::ST_OUT;
      bntg_pkg::ST_OUT:       if (out_ready_i) state_d = bntg_pkg::ST_IDLE;
      default:                state_d = bntg_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.div_sel = bntg_pkg::DIV_REST;
    case (state_q)
      bntg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          cmd_o.start_accept = sts_i.op_start;
          cmd_o.tick_apply   = !sts_i.op_start;
          cmd_o.div_start    = sts_i.op_start;
          cmd_o.div_sel      = sts_i.freq_zero ? bntg_pkg::DIV_REST : bntg_pkg::DIV_BEAT;
        end
      end
      bntg_pkg::ST_WAIT_REST: begin
        cmd_o.rest_load = sts_i.div_done;
      end
      bntg_pkg::ST_WAIT_BEAT: begin
        cmd_o.beat_keep = sts_i.div_done;
        cmd_o.div_start = sts_i.div_done;
        cmd_o.div_sel   = bntg_pkg::DIV_HP;
      end
      bntg_pkg::ST_WAIT_HP: begin
        cmd_o.hp_keep   = sts_i.div_done;
        cmd_o.div_start = sts_i.div_done;
        cmd_o.div_sel   = bntg_pkg::DIV_NUM;
      end
      bntg_pkg::ST_WAIT_NUM: begin
        cmd_o.tone_load = sts_i.div_done;
      end
      bntg_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bntg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bntg_datapath.sv @@
// ----------------------------------------------------------------------------
// bntg_datapath
// Datapath: beat register, note state (half period, period and rest
// counters, phase counter, level), the shared divider and the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bntg_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bntg_pkg::BeatW-1:0]     cfg_wdata_i,
  output      logic [bntg_pkg::BeatW-1:0]     beat_rate_o,
  input  wire logic                           operation_i,
  input  wire logic [bntg_pkg::FreqW-1:0]     note_freq_i,
  input  wire bntg_pkg::cmd_t                 cmd_i,
  output      bntg_pkg::sts_t                 sts_o,
  output      logic                           sound_level_o,
  output      logic                           busy_res_o,
  output      logic                           note_done_o
);

  localparam int unsigned DW = bntg_pkg::DivW;
  localparam int unsigned PW = bntg_pkg::PeriodW;
  localparam int unsigned RW = bntg_pkg::RestW;
  localparam int unsigned FW = bntg_pkg::FreqW;
  localparam int unsigned BW = bntg_pkg::BeatW;

  logic [BW-1:0] beat_q;
  logic [FW-1:0] freq_q;
  logic [DW-1:0] beat_div_q;
  logic [DW-1:0] hp_q;
  logic [DW-1:0] half_period_q, half_period_d;
  logic [PW-1:0] periods_left_q, periods_left_d;
  logic [DW-1:0] phase_q, phase_d;
  logic [RW-1:0] rest_ms_q, rest_ms_d;
  logic          level_q, level_d;
  logic          resting_q, resting_d;
  logic          active_q, active_d;
  logic          out_level_q, out_level_d;
  logic          out_busy_q, out_busy_d;
  logic          out_done_q, out_done_d;

  logic [DW-1:0] beat_eff;
  logic [DW-1:0] dividend;
  logic [DW-1:0] divisor;
  logic [DW-1:0] quotient;
  logic          div_done;
  logic [DW-1:0] phase_inc;
  logic [PW-1:0] periods_dec;
  logic [RW-1:0] rest_dec;

  // a beat rate of zero counts as one
  assign beat_eff = (beat_q == '0) ? DW'(1) : DW'(beat_q);

  // divider operand selection
  always_comb begin
    case (cmd_i.div_sel)
      bntg_pkg::DIV_REST: begin
        dividend = bntg_pkg::MsPerSecond;
        divisor  = beat_eff;
      end
      bntg_pkg::DIV_BEAT: begin
        dividend = bntg_pkg::HalfSecondUs;
        divisor  = beat_eff;
      end
      bntg_pkg::DIV_HP: begin
        dividend = bntg_pkg::UsPerSecond + DW'(freq_q >> 1);
        divisor  = DW'(freq_q);
      end
      bntg_pkg::DIV_NUM: begin
        // half period straight off the divider, hp_q loads in the same cycle
        dividend = beat_div_q;
        divisor  = quotient;
      end
      default: begin
        dividend = '0;
        divisor  = DW'(1);
      end
    endcase
  end

  bntg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  assign sts_o.op_start  = (operation_i == bntg_pkg::OpStart);
  assign sts_o.freq_zero = (note_freq_i == '0);
  assign sts_o.div_done  = div_done;

  assign phase_inc   = phase_q + DW'(1);
  assign periods_dec = periods_left_q - PW'(1);
  assign rest_dec    = rest_ms_q - RW'(1);

  // note state update and result beat
  always_comb begin
    half_period_d  = half_period_q;
    periods_left_d = periods_left_q;
    phase_d        = phase_q;
    rest_ms_d      = rest_ms_q;
    level_d        = level_q;
    resting_d      = resting_q;
    active_d       = active_q;
    out_level_d    = out_level_q;
    out_busy_d     = out_busy_q;
    out_done_d     = out_done_q;

    if (cmd_i.tick_apply) begin
      out_level_d = 1'b0;
      out_done_d  = 1'b0;
      if (active_q) begin
        out_level_d = level_q;
        phase_d     = phase_inc;
        if (resting_q) begin
          if (phase_inc >= bntg_pkg::UsPerMs) begin
            phase_d   = '0;
            rest_ms_d = rest_dec;
            if (rest_dec == '0) begin
              active_d   = 1'b0;
              resting_d  = 1'b0;
              level_d    = 1'b0;
              out_done_d = 1'b1;
            end
          end
        end else if (phase_inc >= half_period_q) begin
          phase_d = '0;
          if (level_q) begin
            level_d = 1'b0;
          end else begin
            periods_left_d = periods_dec;
            if (periods_dec == '0) begin
              active_d   = 1'b0;
              out_done_d = 1'b1;
            end else begin
              level_d = 1'b1;
            end
          end
        end
      end
      out_busy_d = active_d;
    end else if (cmd_i.rest_load || cmd_i.tone_load) begin
      // a start drops whatever note was running
      periods_left_d = '0;
      phase_d        = '0;
      rest_ms_d      = '0;
      level_d        = 1'b0;
      resting_d      = 1'b0;
      active_d       = 1'b0;
      out_done_d     = 1'b0;
      if (cmd_i.rest_load) begin
        if (quotient == '0) begin
          out_done_d = 1'b1;
        end else begin
          resting_d = 1'b1;
          rest_ms_d = quotient[RW-1:0];
          active_d  = 1'b1;
        end
      end else begin
        half_period_d = hp_q;
        if (quotient == '0) begin
          out_done_d = 1'b1;
        end else begin
          periods_left_d = quotient[PW-1:0];
          level_d        = 1'b1;
          active_d       = 1'b1;
        end
      end
      out_level_d = level_d;
      out_busy_d  = active_d;
    end
  end

  // configuration and note control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q         <= bntg_pkg::BeatRateReset;
      half_period_q  <= '0;
      periods_left_q <= '0;
      phase_q        <= '0;
      rest_ms_q      <= '0;
      level_q        <= 1'b0;
      resting_q      <= 1'b0;
      active_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        beat_q <= cfg_wdata_i;
      end
      half_period_q  <= half_period_d;
      periods_left_q <= periods_left_d;
      phase_q        <= phase_d;
      rest_ms_q      <= rest_ms_d;
      level_q        <= level_d;
      resting_q      <= resting_d;
      active_q       <= active_d;
    end
  end

  // operands and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_accept) begin
      freq_q <= note_freq_i;
    end
    if (cmd_i.beat_keep) begin
      beat_div_q <= quotient;
    end
    if (cmd_i.hp_keep) begin
      hp_q <= quotient;
    end
    out_level_q <= out_level_d;
    out_busy_q  <= out_busy_d;
    out_done_q  <= out_done_d;
  end

  assign beat_rate_o   = beat_q;
  assign sound_level_o = out_level_q;
  assign busy_res_o    = out_busy_q;
  assign note_done_o   = out_done_q;

endmodule

`default_nettype wire

@@ rtl/buzzer_note_tone_generator.sv @@
// ----------------------------------------------------------------------------
// buzzer_note_tone_generator
// Square-wave buzzer tone generator, one note or rest at a time.
//
// Input stream: tuser[0] is the operation (0 = one microsecond tick,
// 1 = start a note), tdata carries the note frequency in Hz (0 = rest).
// Output stream: one result beat per input beat, tdata bit 0 is the buzzer
// level, bit 1 says a note is still running, bit 2 pulses on the beat that
// ends a note or rest.
// A tick beat is worked in the cycle it is accepted; its result is offered
// on the next cycle.
// A tone start runs three 20-step divisions on the shared divider (beat
// length, half period, period count); a rest start needs one division.
// One beat is in flight at a time: the input is not ready while a result
// waits, so a stalled receiver holds the input off.
// Reset clears the note state (silent, idle) and sets beat_rate to 2.
// APB: beat_rate at address 0; user writes it only while idle (block does not enforce).
// ----------------------------------------------------------------------------
`default_nettype none

module buzzer_note_tone_generator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [15:0] note_freq
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] operation
  // output stream
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [7:0]  m_axis_tdata_o,   // [0] sound_level, [1] busy_res, [2] note_done
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  bntg_pkg::cmd_t               cmd;
  bntg_pkg::sts_t               sts;
  logic                         cfg_we;
  logic [bntg_pkg::BeatW-1:0]   beat_rate;
  logic                         sound_level;
  logic                         busy_res;
  logic                         note_done;

  // register decode
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == bntg_pkg::RegBeatRate);
  assign prdata = (paddr[2] == bntg_pkg::RegBeatRate) ? 32'(beat_rate) : '0;

  bntg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bntg_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (pwdata[bntg_pkg::BeatW-1:0]),
    .beat_rate_o   (beat_rate),
    .operation_i   (s_axis_tuser_i[0]),
    .note_freq_i   (s_axis_tdata_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .sound_level_o (sound_level),
    .busy_res_o    (busy_res),
    .note_done_o   (note_done)
  );

  // result beat packing
  assign m_axis_tdata_o = {5'b0, note_done, busy_res, sound_level};

endmodule

`default_nettype wire

@@ tb/tb_buzzer_note_tone_generator.sv @@
// ----------------------------------------------------------------------------
// tb_buzzer_note_tone_generator
// Self-checking bench for the buzzer note tone generator. A short table of
// directed beats opens the run (idle ticks, empty notes, rest, tone, abort),
// then random note sequences run under several beat_rate settings. Every
// result beat is compared with a bench-side note predictor. Both streams
// idle at random, and the output is held off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_buzzer_note_tone_generator;

  localparam int unsigned CycleLimit    = 4_000_000;
  localparam int unsigned PhaseItems    = 125;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned SteadyPhase   = 4;
  localparam int unsigned HoldOffAt     = 400;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DirRows       = 25;
  localparam logic [2:0]  BeatRateAddr  = {bntg_pkg::RegBeatRate, 2'b00};

  // one result beat: {level, busy, done}
  typedef struct packed {
    logic level;
    logic busy;
    logic done;
  } tone_res_t;

  typedef struct packed {
    logic        op;
    logic [15:0] freq;
    logic        typed;
    tone_res_t   want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;   // [15:0] note_freq
  logic [0:0]  s_axis_tuser_i;   // [0] operation
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;   // [0] sound_level, [1] busy_res, [2] note_done
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [7:0]  beat_setting;
  logic [19:0] tone_half_us;
  logic [18:0] periods_left;
  logic [19:0] phase_us;
  logic        level_on;
  logic        in_rest;
  logic [9:0]  rest_ms_left;
  logic        note_active;

  tone_res_t   expected_tones[$];
  stim_row_t   directed_rows [DirRows];
  logic [7:0]  beat_plan [NumPhases];

  int unsigned failures      = 0;
  int unsigned results_seen  = 0;
  int unsigned counted_items = 0;
  int unsigned cycles        = 0;
  bit          steady        = 1'b0;

  buzzer_note_tone_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void silence_note();
    note_active  = 1'b0;
    level_on     = 1'b0;
    in_rest      = 1'b0;
    phase_us     = '0;
    periods_left = '0;
    rest_ms_left = '0;
  endfunction

  function automatic void reset_note_state();
    beat_setting = bntg_pkg::BeatRateReset;
    tone_half_us = '0;
    silence_note();
  endfunction

  // next result beat for one accepted input beat; updates the note state
  function automatic tone_res_t predict_tone(input logic op, input logic [15:0] freq);
    int unsigned beat_div;
    int unsigned half_us;
    int unsigned periods;
    int unsigned rest_ms;
    tone_res_t   res;
    res      = '0;
    beat_div = (beat_setting == 8'd0) ? 1 : 32'(beat_setting);
    if (op == bntg_pkg::OpStart) begin
      silence_note();
      if (freq == 16'd0) begin
        rest_ms = 32'(bntg_pkg::MsPerSecond) / beat_div;
        if (rest_ms == 0) begin
          res.done = 1'b1;
        end else begin
          in_rest      = 1'b1;
          rest_ms_left = rest_ms[9:0];
          note_active  = 1'b1;
        end
      end else begin
        // rounded half period, then whole periods that fit in the note
        half_us      = (32'(bntg_pkg::UsPerSecond) + 32'(freq) / 2) / 32'(freq);
        periods      = (32'(bntg_pkg::HalfSecondUs) / beat_div) / half_us;
        tone_half_us = half_us[19:0];
        if (periods == 0) begin
          res.done = 1'b1;
        end else begin
          periods_left = periods[18:0];
          level_on     = 1'b1;
          note_active  = 1'b1;
        end
      end
      res.level = level_on;
    end else if (note_active) begin
      res.level = level_on;
      phase_us  = phase_us + 20'd1;
      if (in_rest) begin
        if (phase_us >= bntg_pkg::UsPerMs) begin
          phase_us     = '0;
          rest_ms_left = rest_ms_left - 10'd1;
          if (rest_ms_left == '0) begin
            silence_note();
            res.done = 1'b1;
          end
        end
      end else if (phase_us >= tone_half_us) begin
        phase_us = '0;
        if (level_on) begin
          level_on = 1'b0;
        end else begin
          periods_left = periods_left - 19'd1;
          if (periods_left == '0) begin
            silence_note();
            res.done = 1'b1;
          end else begin
            level_on = 1'b1;
          end
        end
      end
    end
    res.busy = note_active;
    return res;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s at result %0d: got %0d, expected %0d",
             what, results_seen, got, want);
    failures++;
  endtask

  task automatic check_tone_beat(input logic [7:0] data);
    tone_res_t want;
    if (expected_tones.size() == 0) begin
      report_mismatch("result with nothing expected", int'(data), 0);
    end else begin
      want = expected_tones.pop_front();
      if (data[0] !== want.level) report_mismatch("sound_level", int'(data[0]), int'(want.level));
      if (data[1] !== want.busy)  report_mismatch("busy_res", int'(data[1]), int'(want.busy));
      if (data[2] !== want.done)  report_mismatch("note_done", int'(data[2]), int'(want.done));
    end
    results_seen++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) check_tone_beat(m_axis_tdata_o);
  end

  // output side: random stalls, one long hold-off while the input keeps coming
  initial begin
    bit held_off;
    held_off = 1'b0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held_off && results_seen >= HoldOffAt) begin
        held_off = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      m_axis_tready_i <= steady || ($urandom_range(99) >= 30);
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_item(input logic op, input logic [15:0] freq,
                           input logic typed, input tone_res_t typed_res);
    tone_res_t want;
    if (!steady) begin
      while ($urandom_range(99) < 30) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= freq;
    do @(posedge clk_i); while (!s_axis_tready_o);
    // ticks on an idle block are ignored and do not count
    if (op == bntg_pkg::OpStart || note_active) counted_items++;
    want = predict_tone(op, freq);
    expected_tones.push_back(typed ? typed_res : want);
  endtask

  task automatic write_beat_rate(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BeatRateAddr;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    beat_setting = value;
  endtask

  task automatic drain_results();
    while (expected_tones.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_note_freq();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return 16'd0;
    if (pick < 30) return 16'($urandom_range(1, 700));
    if (pick < 36) return 16'hFFFF;
    return 16'($urandom_range(1, 65535));
  endfunction

  // random note sequences, each note cut short by the next start
  task automatic run_beat_phase();
    int unsigned items_at_start;
    int unsigned pick;
    int unsigned n_ticks;
    int unsigned k;
    items_at_start = counted_items;
    while (counted_items - items_at_start < PhaseItems) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        // stray ticks with junk data
        n_ticks = $urandom_range(1, 4);
        for (k = 0; k < n_ticks; k++)
          send_item(bntg_pkg::OpTick, 16'($urandom), 1'b0, '0);
      end else begin
        // note cut short by the next start
        send_item(bntg_pkg::OpStart, pick_note_freq(), 1'b0, '0);
        n_ticks = $urandom_range(0, 40);
        for (k = 0; k < n_ticks; k++)
          send_item(bntg_pkg::OpTick, 16'($urandom), 1'b0, '0);
      end
    end
  endtask

  initial begin
    int unsigned r;
    int unsigned ph;
    // want = {level, busy, done}; untyped rows go to the predictor
    directed_rows = '{
      '{bntg_pkg::OpTick,  16'hFFFF, 1'b1, 3'b000},  // idle tick, data ignored
      '{bntg_pkg::OpTick,  16'h0000, 1'b1, 3'b000},
      '{bntg_pkg::OpStart, 16'd1,    1'b1, 3'b001},  // no whole period fits: done at once
      '{bntg_pkg::OpStart, 16'd0,    1'b1, 3'b010},  // rest starts silent
      '{bntg_pkg::OpTick,  16'h5555, 1'b0, 3'b000},
      '{bntg_pkg::OpStart, 16'hFFFF, 1'b1, 3'b110},  // aborts the rest, tone starts high
      '{bntg_pkg::OpTick,  16'hAAAA, 1'b0, 3'b000},
      '{bntg_pkg::OpTick,  16'h5555, 1'b0, 3'b000},
      '{bntg_pkg::OpTick,  16'hAAAA, 1'b0, 3'b000},
      '{bntg_pkg::OpTick,  16'h5555, 1'b0, 3'b000},
      '{bntg_pkg::OpTick,  16'hAAAA, 1'b0, 3'b000},
      '{bntg_pkg::OpTick,  16'h5555, 1'b0, 3'b000},
      '{bntg_pkg::OpTick,  16'hAAAA, 1'b0, 3'b000},
      '{bntg_pkg::OpTick,  16'h5555, 1'b0, 3'b000},
      '{bntg_pkg::OpTick,  16'hAAAA, 1'b0, 3'b000},
      '{bntg_pkg::OpTick,  16'h5555, 1'b0, 3'b000},
      '{bntg_pkg::OpTick,  16'hAAAA, 1'b0, 3'b000},
      '{bntg_pkg::OpTick,  16'h5555, 1'b0, 3'b000},
      '{bntg_pkg::OpTick,  16'hAAAA, 1'b0, 3'b000},
      '{bntg_pkg::OpTick,  16'h5555, 1'b0, 3'b000},
      '{bntg_pkg::OpTick,  16'hAAAA, 1'b0, 3'b000},  // half period over: level drops
      '{bntg_pkg::OpTick,  16'h5555, 1'b0, 3'b000},
      '{bntg_pkg::OpTick,  16'hAAAA, 1'b0, 3'b000},
      '{bntg_pkg::OpStart, 16'h8000, 1'b1, 3'b110},  // aborts the running tone
      '{bntg_pkg::OpStart, 16'd2,    1'b1, 3'b001}   // empty note aborts the tone too
    };
    // beat settings per phase: extremes, zero (taken as one), short beats
    beat_plan = '{8'd1, 8'd255, 8'd0, 8'd200, 8'd2, 8'd255, 8'd128, 8'd254, 8'd200, 8'd37};

    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= bntg_pkg::OpTick;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    reset_note_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at the reset beat_rate
    for (r = 0; r < DirRows; r++)
      send_item(directed_rows[r].op, directed_rows[r].freq,
                directed_rows[r].typed, directed_rows[r].want);

    // random phases, each under its own beat_rate
    for (ph = 0; ph < NumPhases; ph++) begin
      s_axis_tvalid_i <= 1'b0;
      drain_results();
      write_beat_rate(beat_plan[ph]);
      steady = (ph == SteadyPhase);
      run_beat_phase();
    end

    s_axis_tvalid_i <= 1'b0;
    steady = 1'b0;
    drain_results();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
